@@ design/iircomp_pkg.sv @@
// Shared types and constants of the third-order IIR compensator.
// Used by iircomp_datapath and third_order_iir_compensator.
package iircomp_pkg;

    localparam int FILTER_ORDER = 3;

    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 32;
    localparam int LIMIT_W     = 31;
    localparam int COEF_FRAC   = 28;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int NUM_TERMS   = 2 * FILTER_ORDER + 1;
    localparam int ACC_W       = PROD_W + $clog2(NUM_TERMS);
    localparam int RND_W       = ACC_W - COEF_FRAC;

    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // register map: ff coefficients first, then fb coefficients, then the limit
    localparam int FB_IDX_BASE = FILTER_ORDER + 1;
    localparam int LIMIT_IDX   = 2 * FILTER_ORDER + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(550502400);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [LIMIT_W-1:0]         limit_t;

    typedef sample_t [FILTER_ORDER-1:0] hist_t;
    typedef coef_t   [FILTER_ORDER:0]   ff_coefs_t;
    typedef coef_t   [FILTER_ORDER-1:0] fb_coefs_t;

    typedef struct packed {
        sample_t drive;
        logic    limited;
    } result_t;

endpackage

@@ design/iircomp_datapath.sv @@
// Sum of products, rounding and symmetric clamp for one sample.
// Depends on iircomp_pkg.
module iircomp_datapath
    import iircomp_pkg::*;
(
    input  sample_t   x,
    input  hist_t     in_hist,
    input  hist_t     out_hist,
    input  ff_coefs_t ff_coef,
    input  fb_coefs_t fb_coef,
    input  limit_t    limit,
    output result_t   result
);

    logic signed [PROD_W-1:0] ff_prod [FILTER_ORDER+1];
    logic signed [PROD_W-1:0] fb_prod [FILTER_ORDER];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  biased;
    logic signed [RND_W-1:0]  rnd;
    logic signed [RND_W-1:0]  lim_pos;
    logic signed [RND_W-1:0]  lim_neg;
    logic signed [RND_W-1:0]  clamped;

    assign ff_prod[0] = $signed(ff_coef[0]) * $signed(x);

    for (genvar k = 0; k < FILTER_ORDER; k++)
    begin : g_prod
        assign ff_prod[k+1] = $signed(ff_coef[k+1]) * $signed(in_hist[k]);
        assign fb_prod[k]   = $signed(fb_coef[k]) * $signed(out_hist[k]);
    end

    always_comb
    begin
        acc = ACC_W'(ff_prod[0]);
        for (int k = 0; k < FILTER_ORDER; k++)
        begin
            acc = acc + ACC_W'(ff_prod[k+1]) + ACC_W'(fb_prod[k]);
        end
    end

    // round to nearest, halves toward +inf
    assign biased  = acc + (ACC_W'(1) <<< (COEF_FRAC - 1));
    assign rnd     = RND_W'(biased >>> COEF_FRAC);
    assign lim_pos = $signed({{(RND_W-LIMIT_W){1'b0}}, limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        result.limited = 1'b1;
        if (rnd > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (rnd < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped        = rnd;
            result.limited = 1'b0;
        end
        result.drive = sample_t'(clamped);
    end

endmodule

@@ design/third_order_iir_compensator.sv @@
// Top level of the third-order direct-form-I IIR compensator.
// Depends on iircomp_pkg and iircomp_datapath.
//
// Usage:
//   s_* carries one error sample per request (s_tdata = error_sample, Q16.16).
//   m_* returns one result per sample: m_tdata = drive_value (Q16.16),
//   m_tuser = was_limited.
//   cfg_* writes registers: 0..3 feedforward coefficients, 4..6 feedback
//   coefficients (Q4.28, added), 7 output limit (Q16.16). Other indexes are
//   ignored. cfg_ready is always high; write only while the filter is idle.
// Timing:
//   A sample is held in the input register while the seven products,
//   the sum, rounding and clamp are formed, then lands in the result
//   register. Throughput is one sample per cycle while m_tready is high,
//   as the multiply-accumulate feeding the output history is combinational.
// Reset clears both histories and all coefficients and sets the limit to
// 8400.0. When m_tready is low the result holds, one more sample is taken
// into an empty input register, then s_tready drops until the result leaves.
module third_order_iir_compensator
    import iircomp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // [31:0] error_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [31:0] drive_value
    output logic [0:0]            m_tuser,    // [0] was_limited
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic      in_valid_reg;
    sample_t   x_reg;
    logic      out_valid_reg;
    result_t   result_reg;
    hist_t     in_hist_reg;
    hist_t     out_hist_reg;
    ff_coefs_t ff_coef_reg;
    fb_coefs_t fb_coef_reg;
    limit_t    limit_reg;
    result_t   result_next;
    logic      advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    iircomp_datapath u_datapath
    (
        .x        (x_reg),
        .in_hist  (in_hist_reg),
        .out_hist (out_hist_reg),
        .ff_coef  (ff_coef_reg),
        .fb_coef  (fb_coef_reg),
        .limit    (limit_reg),
        .result   (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            x_reg <= sample_t'(s_tdata);
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hist_reg  <= '0;
            out_hist_reg <= '0;
        end
        else if (advance)
        begin
            for (int k = FILTER_ORDER - 1; k > 0; k--)
            begin
                in_hist_reg[k]  <= in_hist_reg[k-1];
                out_hist_reg[k] <= out_hist_reg[k-1];
            end
            in_hist_reg[0]  <= x_reg;
            out_hist_reg[0] <= result_next.drive;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_coef_reg <= '0;
            fb_coef_reg <= '0;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int k = 0; k <= FILTER_ORDER; k++)
            begin
                if (cfg_index == CFG_IDX_W'(k))
                begin
                    ff_coef_reg[k] <= coef_t'(cfg_data);
                end
            end
            for (int k = 0; k < FILTER_ORDER; k++)
            begin
                if (cfg_index == CFG_IDX_W'(FB_IDX_BASE + k))
                begin
                    fb_coef_reg[k] <= coef_t'(cfg_data);
                end
            end
            if (cfg_index == CFG_IDX_W'(LIMIT_IDX))
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg.drive;
    assign m_tuser  = result_reg.limited;

endmodule

@@ design/iircomp_checker.sv @@
// Port-level checks for third_order_iir_compensator, bound to the top level.
// Watches only the stream channels of the top level.
module iircomp_assertions
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,
    input  logic [0:0]            m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != 32'h8000_0000)
        else $error("drive value beyond symmetric limit");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted sample produced no result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind third_order_iir_compensator iircomp_assertions u_iircomp_assertions (.*);
